@@ rtl/wrr_pkg.sv @@
`default_nettype none

package wrr_pkg;

    localparam int ID_W       = 16;
    localparam int WEIGHT_W   = 8;
    localparam int CREDIT_W   = 16;
    localparam int QUANTA_W   = 8;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 4;

    localparam logic [QUANTA_W-1:0] QUANTA_RESET = 8'd1;

    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_REQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_REFILL_RD,
        ST_REFILL_WR,
        ST_DONE
    } wrr_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic add_write;
        logic scan_start;
        logic probe_hit;
        logic probe_next;
        logic refill_start;
        logic refill_write;
        logic rescan_start;
        logic res_full;
        logic res_none;
        logic load_out;
    } wrr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_add;
        logic full;
        logic empty;
        logic credit_nz;
        logic scan_last;
        logic refill_last;
        logic refill_nz;
        logic refilled;
        logic out_free;
    } wrr_sts_t;

endpackage

`default_nettype wire

@@ rtl/wrr_if.sv @@
`default_nettype none

interface wrr_in_if
    import wrr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                func;
    logic [ID_W-1:0]     task_id;
    logic [WEIGHT_W-1:0] weight;

    modport source (output valid, output func, output task_id, output weight, input ready);
    modport sink   (input valid, input func, input task_id, input weight, output ready);
endinterface

interface wrr_out_if
    import wrr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic                  granted;
    logic [SLOT_OUT_W-1:0] grant_slot;
    logic [ID_W-1:0]       grant_task_id;
    logic                  refilled;

    modport source (output valid, output status, output granted, output grant_slot,
                    output grant_task_id, output refilled, input ready);
    modport sink   (input valid, input status, input granted, input grant_slot,
                    input grant_task_id, input refilled, output ready);
endinterface

`default_nettype wire

@@ rtl/wrr_ram.sv @@
`default_nettype none

module wrr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/wrr_ctrl.sv @@
`default_nettype none

module wrr_ctrl
    import wrr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire wrr_sts_t sts,
    output wrr_cmd_t      cmd
);

    wrr_state_t state_reg;
    wrr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.is_add)
                begin
                    if (sts.full)
                    begin
                        cmd.res_full = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_ADD;
                    end
                end
                else if (sts.empty)
                begin
                    cmd.res_none = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_PROBE_RD;
                end
            end
            ST_ADD:
            begin
                cmd.add_write = 1'b1;
                state_next    = ST_DONE;
            end
            ST_PROBE_RD:
            begin
                state_next = ST_PROBE_CHK;
            end
            ST_PROBE_CHK:
            begin
                if (sts.credit_nz)
                begin
                    cmd.probe_hit = 1'b1;
                    state_next    = ST_DONE;
                end
                else if (sts.scan_last)
                begin
                    if (sts.refilled)
                    begin
                        cmd.res_none = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        cmd.refill_start = 1'b1;
                        state_next       = ST_REFILL_RD;
                    end
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_PROBE_RD;
                end
            end
            ST_REFILL_RD:
            begin
                state_next = ST_REFILL_WR;
            end
            ST_REFILL_WR:
            begin
                cmd.refill_write = 1'b1;
                if (!sts.refill_last)
                begin
                    state_next = ST_REFILL_RD;
                end
                else if (sts.refill_nz)
                begin
                    cmd.rescan_start = 1'b1;
                    state_next       = ST_PROBE_RD;
                end
                else
                begin
                    cmd.res_none = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/wrr_dp.sv @@
`default_nettype none

module wrr_dp
    import wrr_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire wrr_cmd_t              cmd,
    output wrr_sts_t                   sts,
    input  wire logic                  cfg_we,
    input  wire logic [QUANTA_W-1:0]   cfg_wdata,
    input  wire logic                  func,
    input  wire logic [ID_W-1:0]       task_id,
    input  wire logic [WEIGHT_W-1:0]   weight,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output logic      [STATUS_W-1:0]   rsp_status,
    output logic                       rsp_granted,
    output logic      [SLOT_OUT_W-1:0] rsp_slot,
    output logic      [ID_W-1:0]       rsp_task_id,
    output logic                       rsp_refilled
);

    localparam int SLOT_W     = $clog2(MAX_TASKS);
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);
    localparam int SLOT_EXT_W = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;

    logic [QUANTA_W-1:0]   quanta_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [SLOT_W-1:0]     ptr_reg;
    logic                  out_valid_reg;

    logic                  func_reg;
    logic [ID_W-1:0]       id_reg;
    logic [WEIGHT_W-1:0]   weight_reg;
    logic [SLOT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]      steps_reg;
    logic                  nz_reg;
    logic                  refilled_reg;

    logic [STATUS_W-1:0]   res_status_reg;
    logic                  res_granted_reg;
    logic [SLOT_OUT_W-1:0] res_slot_reg;
    logic [ID_W-1:0]       res_id_reg;
    logic                  res_refilled_reg;

    logic [STATUS_W-1:0]   out_status_reg;
    logic                  out_granted_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic [ID_W-1:0]       out_id_reg;
    logic                  out_refilled_reg;

    logic [ID_W-1:0]       id_rdata;
    logic [WEIGHT_W-1:0]   weight_rdata;
    logic [CREDIT_W-1:0]   credit_rdata;

    logic [SLOT_W-1:0]     add_slot;
    logic [CNT_W-1:0]      idx_inc;
    logic [SLOT_W-1:0]     idx_wrap;
    logic [SLOT_W-1:0]     ptr_start;
    logic [WEIGHT_W-1:0]   mult_a;
    logic [CREDIT_W-1:0]   product;
    logic                  credit_we;
    logic [SLOT_W-1:0]     credit_waddr;
    logic [CREDIT_W-1:0]   credit_wdata;
    logic [SLOT_EXT_W-1:0] add_slot_ext;
    logic [SLOT_EXT_W-1:0] idx_slot_ext;

    assign add_slot  = count_reg[SLOT_W-1:0];
    assign idx_inc   = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_wrap  = (idx_inc == count_reg) ? '0 : idx_inc[SLOT_W-1:0];
    assign ptr_start = (CNT_W'(ptr_reg) >= count_reg) ? '0 : ptr_reg;

    // one shared 8x8 multiplier: new entry at add, stored weight at refill
    assign mult_a  = cmd.add_write ? weight_reg : weight_rdata;
    assign product = CREDIT_W'(mult_a) * CREDIT_W'(quanta_reg);

    assign credit_we    = cmd.add_write | cmd.probe_hit | cmd.refill_write;
    assign credit_waddr = cmd.add_write ? add_slot : idx_reg;
    assign credit_wdata = cmd.probe_hit ? (credit_rdata - CREDIT_W'(1)) : product;

    assign add_slot_ext = SLOT_EXT_W'(add_slot);
    assign idx_slot_ext = SLOT_EXT_W'(idx_reg);

    wrr_ram #(.WIDTH(ID_W), .DEPTH(MAX_TASKS)) u_id_ram (
        .clk   (clk),
        .we    (cmd.add_write),
        .waddr (add_slot),
        .wdata (id_reg),
        .raddr (idx_reg),
        .rdata (id_rdata)
    );

    wrr_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_TASKS)) u_weight_ram (
        .clk   (clk),
        .we    (cmd.add_write),
        .waddr (add_slot),
        .wdata (weight_reg),
        .raddr (idx_reg),
        .rdata (weight_rdata)
    );

    wrr_ram #(.WIDTH(CREDIT_W), .DEPTH(MAX_TASKS)) u_credit_ram (
        .clk   (clk),
        .we    (credit_we),
        .waddr (credit_waddr),
        .wdata (credit_wdata),
        .raddr (idx_reg),
        .rdata (credit_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quanta_reg    <= QUANTA_RESET;
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                quanta_reg <= cfg_wdata;
            end
            if (cmd.add_write)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.probe_hit)
            begin
                ptr_reg <= idx_wrap;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= func;
            id_reg     <= task_id;
            weight_reg <= weight;
        end

        if (cmd.scan_start || cmd.rescan_start)
        begin
            idx_reg   <= ptr_start;
            steps_reg <= '0;
        end
        else if (cmd.refill_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.probe_next || cmd.refill_write)
        begin
            idx_reg <= idx_wrap;
            if (cmd.probe_next)
            begin
                steps_reg <= steps_reg + CNT_W'(1);
            end
        end

        if (cmd.scan_start)
        begin
            refilled_reg <= 1'b0;
        end
        else if (cmd.rescan_start)
        begin
            refilled_reg <= 1'b1;
        end

        if (cmd.refill_start)
        begin
            nz_reg <= 1'b0;
        end
        else if (cmd.refill_write)
        begin
            nz_reg <= sts.refill_nz;
        end

        if (cmd.res_full || cmd.res_none)
        begin
            res_status_reg   <= cmd.res_full ? STATUS_FULL : STATUS_NONE;
            res_granted_reg  <= 1'b0;
            res_slot_reg     <= '0;
            res_id_reg       <= '0;
            res_refilled_reg <= 1'b0;
        end
        else if (cmd.add_write)
        begin
            res_status_reg   <= STATUS_OK;
            res_granted_reg  <= 1'b0;
            res_slot_reg     <= add_slot_ext[SLOT_OUT_W-1:0];
            res_id_reg       <= '0;
            res_refilled_reg <= 1'b0;
        end
        else if (cmd.probe_hit)
        begin
            res_status_reg   <= STATUS_OK;
            res_granted_reg  <= 1'b1;
            res_slot_reg     <= idx_slot_ext[SLOT_OUT_W-1:0];
            res_id_reg       <= id_rdata;
            res_refilled_reg <= refilled_reg;
        end

        if (cmd.load_out)
        begin
            out_status_reg   <= res_status_reg;
            out_granted_reg  <= res_granted_reg;
            out_slot_reg     <= res_slot_reg;
            out_id_reg       <= res_id_reg;
            out_refilled_reg <= res_refilled_reg;
        end
    end

    always_comb
    begin
        sts             = '0;
        sts.is_add      = (func_reg == FUNC_ADD);
        sts.full        = (count_reg == CNT_W'(MAX_TASKS));
        sts.empty       = (count_reg == '0);
        sts.credit_nz   = (credit_rdata != '0);
        sts.scan_last   = ((steps_reg + CNT_W'(1)) == count_reg);
        sts.refill_last = (idx_inc == count_reg);
        sts.refill_nz   = nz_reg | (product != '0);
        sts.refilled    = refilled_reg;
        sts.out_free    = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid    = out_valid_reg;
    assign rsp_status   = out_status_reg;
    assign rsp_granted  = out_granted_reg;
    assign rsp_slot     = out_slot_reg;
    assign rsp_task_id  = out_id_reg;
    assign rsp_refilled = out_refilled_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("entry count beyond table size");

    a_ptr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CNT_W'(ptr_reg) < count_reg))
        else $error("round-robin pointer outside filled slots");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_write |=> (count_reg == ($past(count_reg) + CNT_W'(1))))
        else $error("add did not advance entry count");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over an untaken result");

endmodule

`default_nettype wire

@@ rtl/weighted_round_robin_scheduler.sv @@
// Weighted round-robin credit scheduler.
// req channel (valid/ready): func selects add (append id and weight to the
//   table, credit = weight * quantum) or request (grant the next
//   entry with credit, scanning round-robin from the pointer).
// rsp channel (valid/ready): one result per transfer on req: status, granted,
//   slot, granted task id and a flag telling that all credits were refilled.
// cfg_we/cfg_wdata write the credit quantum; write only while the block is idle.
// Sequencing: one item at a time. An add passes decode and the table write
//   before its result is loaded. A request probes slot by slot, each probe
//   a read state and a check state, since each credit read goes through the
//   registered read port of the credit memory. A request that finds no
//   credit makes a failed pass, then a refill (one weight read and multiply
//   per slot), and rescans when any refilled credit is nonzero.
// req.ready is high only while the controller waits for an item; the result
//   sits in an output register, so the next item is taken while it waits.
//   A stalled rsp holds the result and the next one waits behind it.
// Reset clears the entry count, pointer and output valid, and sets the
//   quantum to 1; table memories are not cleared.
`default_nettype none

module weighted_round_robin_scheduler
    import wrr_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    wrr_in_if.sink                   req,
    wrr_out_if.source                rsp,
    input  wire logic                cfg_we,
    input  wire logic [QUANTA_W-1:0] cfg_wdata
);

    wrr_cmd_t cmd;
    wrr_sts_t sts;
    logic     in_ready;

    // sequencer: decides add/scan/refill steps and when a result moves out
    wrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    assign req.ready = in_ready;

    // table memories, count/pointer, multiplier and output register
    wrr_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .func         (req.func),
        .task_id      (req.task_id),
        .weight       (req.weight),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .rsp_status   (rsp.status),
        .rsp_granted  (rsp.granted),
        .rsp_slot     (rsp.grant_slot),
        .rsp_task_id  (rsp.grant_task_id),
        .rsp_refilled (rsp.refilled)
    );

endmodule

`default_nettype wire
